### hw/rtl/xorshift_range_random_macros.svh
// Assertion macros used by the checker file of the range-limited xorshift generator.
`ifndef XORSHIFT_RANGE_RANDOM_MACROS_SVH
`define XORSHIFT_RANGE_RANDOM_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define XRR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define XRR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/xrr_pkg.sv
// Shared types, constants and functions of the range-limited xorshift generator.
package xrr_pkg;

    // Scrambling multiplier and xor-shift distances.
    localparam logic [63:0] XS_MULT    = 64'h2545F4914F6CDD1D;
    localparam int          XS_SHIFT_A = 12;
    localparam int          XS_SHIFT_B = 25;
    localparam int          XS_SHIFT_C = 27;

    // Generator state after reset.
    localparam logic [63:0] STATE_RESET = 64'd1;

    // Default depth of the job queue between front and back.
    localparam int XRR_QUEUE_DEPTH = 2;

    // Number of quotient bits worked by the divider, one per cycle.
    localparam int DIV_STEPS = 64;

    // Item modes.
    typedef enum logic [0:0] {
        MODE_SEED = 1'b0,
        MODE_DRAW = 1'b1
    } xrr_mode_t;

    // One draw handed from front to back: advanced state and the range.
    typedef struct packed {
        logic [63:0] state;
        logic [63:0] lower;
        logic [63:0] upper;
    } xrr_job_t;

    // Back-end sequencer states.
    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MUL_LL,
        BK_MUL_LH,
        BK_MUL_HL,
        BK_DIV,
        BK_DONE
    } xrr_back_state_t;

    // One xorshift64 step: right 12, left 25, right 27.
    function automatic logic [63:0] xs_advance(input logic [63:0] s);
        logic [63:0] t;
        t = s ^ (s >> XS_SHIFT_A);
        t = t ^ (t << XS_SHIFT_B);
        t = t ^ (t >> XS_SHIFT_C);
        return t;
    endfunction

endpackage

### hw/rtl/xrr_queue.sv
// Small job queue that decouples the front end from the back end.
module xrr_queue
    import xrr_pkg::*;
#(
    parameter int DEPTH = XRR_QUEUE_DEPTH
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  xrr_job_t wr_data,
    output logic     full,
    input  logic     pop,
    output xrr_job_t rd_data,
    output logic     empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    xrr_job_t        slot_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg;
    logic [PW-1:0]   rd_ptr_next;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    logic            do_push;
    logic            do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = slot_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Job storage; payload only, no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

### hw/rtl/xrr_front.sv
// Front end: holds the generator state, loads seeds and queues advanced states for draws.
module xrr_front
    import xrr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic        mode,
    input  logic [63:0] seed_value,
    input  logic [63:0] lower_bound,
    input  logic [63:0] upper_bound,
    output logic        job_push,
    output xrr_job_t    job
);

    logic [63:0] state_reg;
    logic [63:0] state_next;
    logic [63:0] state_adv;
    logic        is_draw;

    assign state_adv = xs_advance(state_reg);
    assign is_draw   = (mode == MODE_DRAW);

    // A draw hands the advanced state and its range to the back end.
    assign job_push  = accept && is_draw;
    assign job.state = state_adv;
    assign job.lower = lower_bound;
    assign job.upper = upper_bound;

    // A seed replaces the state; a draw moves it one step.
    always_comb
    begin
        state_next = state_reg;
        if (accept)
        begin
            state_next = is_draw ? state_adv : seed_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= STATE_RESET;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### hw/rtl/xrr_back.sv
// Back end: scrambling multiply, iterative range reduction and the result register.
module xrr_back
    import xrr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        job_empty,
    input  xrr_job_t    job,
    output logic        job_pop,
    output logic        empty,
    input  logic        pop,
    output logic [63:0] drawn_value
);

    localparam int CNT_W = $clog2(DIV_STEPS);

    xrr_back_state_t state_reg;
    xrr_back_state_t state_next;

    logic [63:0]      mult_a_reg;
    logic [63:0]      mult_a_next;
    logic [63:0]      lower_reg;
    logic [63:0]      lower_next;
    logic [63:0]      upper_reg;
    logic [63:0]      upper_next;
    logic [63:0]      acc_reg;
    logic [63:0]      acc_next;
    logic [63:0]      span_reg;
    logic [63:0]      span_next;
    logic             range_empty_reg;
    logic             range_empty_next;
    logic [63:0]      rem_reg;
    logic [63:0]      rem_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [63:0]      out_data_reg;
    logic [63:0]      out_data_next;

    logic             out_load;
    logic             div_last;
    logic [31:0]      mul_op_a;
    logic [31:0]      mul_op_b;
    logic [63:0]      mul_prod;
    logic [64:0]      trial;
    logic             trial_fits;

    assign div_last    = (cnt_reg == CNT_W'(DIV_STEPS - 1));
    assign empty       = !out_valid_reg;
    assign drawn_value = out_data_reg;

    // Next state of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (!job_empty)
                begin
                    state_next = BK_MUL_LL;
                end
            end
            BK_MUL_LL: state_next = BK_MUL_LH;
            BK_MUL_LH: state_next = BK_MUL_HL;
            BK_MUL_HL: state_next = range_empty_reg ? BK_DONE : BK_DIV;
            BK_DIV:
            begin
                if (div_last)
                begin
                    state_next = BK_DONE;
                end
            end
            BK_DONE:
            begin
                if (!out_valid_reg)
                begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    // Sequencer strobes.
    always_comb
    begin
        job_pop  = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            BK_IDLE: job_pop  = !job_empty;
            BK_DONE: out_load = !out_valid_reg;
            default:
            begin
                job_pop  = 1'b0;
                out_load = 1'b0;
            end
        endcase
    end

    // One shared 32 by 32 multiplier; the product is the low half of state times constant.
    always_comb
    begin
        case (state_reg)
            BK_MUL_LH:
            begin
                mul_op_a = mult_a_reg[31:0];
                mul_op_b = XS_MULT[63:32];
            end
            BK_MUL_HL:
            begin
                mul_op_a = mult_a_reg[63:32];
                mul_op_b = XS_MULT[31:0];
            end
            default:
            begin
                mul_op_a = mult_a_reg[31:0];
                mul_op_b = XS_MULT[31:0];
            end
        endcase
    end

    assign mul_prod   = 64'(mul_op_a) * 64'(mul_op_b);

    // Restoring division step: shift in one dividend bit, subtract the span if it fits.
    assign trial      = {rem_reg, acc_reg[63]};
    assign trial_fits = (trial >= {1'b0, span_reg});

    // Datapath registers.
    always_comb
    begin
        mult_a_next      = mult_a_reg;
        lower_next       = lower_reg;
        upper_next       = upper_reg;
        acc_next         = acc_reg;
        span_next        = span_reg;
        range_empty_next = range_empty_reg;
        rem_next         = rem_reg;
        cnt_next         = cnt_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (job_pop)
                begin
                    mult_a_next = job.state;
                    lower_next  = job.lower;
                    upper_next  = job.upper;
                end
            end
            BK_MUL_LL:
            begin
                acc_next         = mul_prod;
                span_next        = upper_reg - lower_reg;
                range_empty_next = (upper_reg <= lower_reg);
            end
            BK_MUL_LH:
            begin
                acc_next = acc_reg + {mul_prod[31:0], 32'd0};
            end
            BK_MUL_HL:
            begin
                acc_next = acc_reg + {mul_prod[31:0], 32'd0};
                rem_next = '0;
                cnt_next = '0;
            end
            BK_DIV:
            begin
                rem_next = trial_fits ? 64'(trial - {1'b0, span_reg}) : trial[63:0];
                acc_next = {acc_reg[62:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    // Result register: filled only when free, emptied by a pop.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_data_next  = range_empty_reg ? lower_reg : rem_reg + lower_reg;
        end
        else if (pop && out_valid_reg)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    // Payload registers, no reset.
    always_ff @(posedge clk)
    begin
        mult_a_reg      <= mult_a_next;
        lower_reg       <= lower_next;
        upper_reg       <= upper_next;
        acc_reg         <= acc_next;
        span_reg        <= span_next;
        range_empty_reg <= range_empty_next;
        rem_reg         <= rem_next;
        out_data_reg    <= out_data_next;
    end

endmodule

### hw/rtl/xorshift_range_random.sv
// Top level of the xorshift64* generator with range reduction.
//
//  Channel   Direction  Handshake        Fields
//  items     in         push / full      mode, seed_value, lower_bound, upper_bound
//  results   out        pop / empty      drawn_value
//
// A seed load updates the front-end state register and gives no result.
// A draw in the back end is a fetch, three 32x32 multiply steps, 64 restoring-divider
// steps (one quotient bit each) and a result write that waits while the result is unread.
// An empty range skips the divider.
// Up to QUEUE_DEPTH draws wait between front and back; full rises when that queue fills.
// Reset sets the generator state to one and empties the queue and result register.
module xorshift_range_random
    import xrr_pkg::*;
#(
    parameter int QUEUE_DEPTH = XRR_QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic        mode,
    input  logic [63:0] seed_value,
    input  logic [63:0] lower_bound,
    input  logic [63:0] upper_bound,
    output logic        empty,
    input  logic        pop,
    output logic [63:0] drawn_value
);

    xrr_job_t front_job;
    xrr_job_t back_job;
    logic     front_push;
    logic     queue_full;
    logic     queue_empty;
    logic     back_pop;
    logic     accept;

    // An item transaction completes whenever the queue has room.
    assign full   = queue_full;
    assign accept = push && !queue_full;

    xrr_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .mode        (mode),
        .seed_value  (seed_value),
        .lower_bound (lower_bound),
        .upper_bound (upper_bound),
        .job_push    (front_push),
        .job         (front_job)
    );

    xrr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (front_push),
        .wr_data (front_job),
        .full    (queue_full),
        .pop     (back_pop),
        .rd_data (back_job),
        .empty   (queue_empty)
    );

    xrr_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .job_empty   (queue_empty),
        .job         (back_job),
        .job_pop     (back_pop),
        .empty       (empty),
        .pop         (pop),
        .drawn_value (drawn_value)
    );

endmodule

### hw/rtl/xrr_checker.sv
// Port-level assertions for the range-limited xorshift generator and their bind.
`include "xorshift_range_random_macros.svh"

module xrr_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        push,
    input logic        full,
    input logic        empty,
    input logic        pop,
    input logic [63:0] drawn_value
);

    // A result that is not taken stays on the ports unchanged.
    `XRR_ASSERT_NEXT(a_result_holds, !empty && !pop, !empty && $stable(drawn_value), "result changed while stalled")

    // The single result register is never refilled in the cycle it is drained.
    `XRR_ASSERT_NEXT(a_pop_drains, !empty && pop, empty, "result register refilled during a pop")

    // The queue can only fill on an accepted item transaction.
    `XRR_ASSERT_NOW(a_full_needs_push, $rose(full), $past(push && !full), "full rose without an accepted item")

endmodule

bind xorshift_range_random xrr_checker u_xrr_checker (.*);

### sim/tb_xorshift_range_random.sv
// Self-checking testbench for the xorshift64* generator with range reduction.
`timescale 1ns / 1ps

module tb_xorshift_range_random;
    import xrr_pkg::*;

    localparam logic [63:0] ALL_ONES    = {64{1'b1}};
    localparam logic [63:0] HALF_RANGE  = 64'h8000_0000_0000_0000;
    localparam int          CYCLE_LIMIT = 700000;
    localparam int          SETTLE_CYCLES = 100;
    localparam int          PRINT_LIMIT = 100;

    // Clock, reset and block ports; every input starts at a known value.
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic        mode = MODE_SEED;
    logic [63:0] seed_value = '0;
    logic [63:0] lower_bound = '0;
    logic [63:0] upper_bound = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic [63:0] drawn_value;

    // Shadow generator state and the draws still owed by the block.
    logic [63:0] shadow_state;
    logic [63:0] expected_draws[$];
    int          error_count = 0;
    int          cycle_count = 0;
    bit          idle_on = 1'b1;

    xorshift_range_random i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .mode        (mode),
        .seed_value  (seed_value),
        .lower_bound (lower_bound),
        .upper_bound (upper_bound),
        .empty       (empty),
        .pop         (pop),
        .drawn_value (drawn_value)
    );

    // Free-running clock with a 4 ns period.
    always #2 clk = ~clk;

    // Global watchdog so that a hung handshake ends the run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Prints one line per mismatch, up to a cap, and always counts it.
    task automatic report_error(input string what, input logic [63:0] want,
                                input logic [63:0] got);
        if (error_count < PRINT_LIMIT)
            $display("ERROR at %0t: %s expected %h got %h", $time, what, want, got);
        error_count++;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Mostly short gaps, a few long ones, none while idling is switched off.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 4);
        return $urandom_range(10, 40);
    endfunction

    // One xorshift64 step with shifts right 12, left 25, right 27.
    function automatic logic [63:0] xorshift_step(input logic [63:0] s);
        logic [63:0] t;
        t = s ^ (s >> 12);
        t = t ^ (t << 25);
        t = t ^ (t >> 27);
        return t;
    endfunction

    // Updates the shadow state for one accepted transaction and, for a draw, queues its result.
    task automatic predict_transaction(input xrr_mode_t m, input logic [63:0] seed,
                                       input logic [63:0] lo, input logic [63:0] hi);
        logic [63:0] scrambled;
        if (m == MODE_SEED)
        begin
            shadow_state = seed;
        end
        else
        begin
            shadow_state = xorshift_step(shadow_state);
            scrambled = shadow_state * XS_MULT;
            if (hi > lo)
                expected_draws.push_back((scrambled % (hi - lo)) + lo);
            else
                expected_draws.push_back(lo);
        end
    endtask

    // Offers one transaction, holds it until accepted, then idles at random.
    task automatic send_item(input xrr_mode_t m, input logic [63:0] seed,
                             input logic [63:0] lo, input logic [63:0] hi);
        int gap;
        push        <= 1'b1;
        mode        <= m;
        seed_value  <= seed;
        lower_bound <= lo;
        upper_bound <= hi;
        @(posedge clk);
        while (full)
            @(posedge clk);
        predict_transaction(m, seed, lo, hi);
        gap = pick_gap();
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_draw(input logic [63:0] lo, input logic [63:0] hi);
        send_item(MODE_DRAW, rand64(), lo, hi);
    endtask

    task automatic send_seed(input logic [63:0] seed);
        send_item(MODE_SEED, seed, rand64(), rand64());
    endtask

    // Stops sending and waits until every expected draw has come back.
    task automatic drain_results();
        push <= 1'b0;
        @(posedge clk);
        while (expected_draws.size() != 0)
            @(posedge clk);
    endtask

    // Picks a range of one of several shapes: narrow, wide, random or empty.
    task automatic pick_range(output logic [63:0] lo, output logic [63:0] hi);
        case ($urandom_range(0, 5))
            0:
            begin
                lo = rand64();
                hi = lo + 64'($urandom_range(1, 1000));
            end
            1:
            begin
                lo = 64'($urandom_range(0, 100));
                hi = 64'($urandom_range(101, 5000));
            end
            2:
            begin
                lo = 64'd0;
                hi = rand64() >> $urandom_range(0, 63);
            end
            3:
            begin
                hi = rand64();
                lo = hi + 64'($urandom_range(0, 3));
            end
            4:
            begin
                lo = rand64() >> $urandom_range(32, 63);
                hi = ALL_ONES - 64'($urandom_range(0, 100));
            end
            default:
            begin
                lo = rand64();
                hi = rand64();
            end
        endcase
    endtask

    // Draws straight from the reset state of one.
    task automatic test_reset_draws();
        send_draw(64'd0, ALL_ONES);
        send_draw(64'd0, 64'd0);
        send_draw(64'd5, 64'd17);
    endtask

    // Empty ranges return the lower bound while the state still advances.
    task automatic test_empty_ranges();
        send_draw(64'd7, 64'd7);
        send_draw(ALL_ONES, 64'd0);
        send_draw(ALL_ONES, ALL_ONES);
        send_draw(64'd100, 64'd99);
        send_draw(64'd0, 64'd1000);
    endtask

    // A zero seed locks the state at zero; a later seed recovers it.
    task automatic test_zero_seed();
        send_seed(64'd0);
        send_draw(64'd0, ALL_ONES);
        send_draw(64'd12345, 64'd99999);
        send_draw(rand64(), rand64());
        send_seed(ALL_ONES);
        send_draw(64'd0, ALL_ONES);
    endtask

    // Spans of one, halves of the number line and the widest span.
    task automatic test_extreme_ranges();
        send_seed(rand64());
        send_draw(64'd0, 64'd1);
        send_draw(ALL_ONES - 64'd1, ALL_ONES);
        send_draw(64'd0, HALF_RANGE);
        send_draw(HALF_RANGE, ALL_ONES);
        send_draw(64'd1, ALL_ONES);
        send_draw(64'd0, ALL_ONES);
        send_seed(HALF_RANGE);
        send_draw(64'd3, 64'd4);
    endtask

    // Transactions back to back with no idling on either side.
    task automatic test_back_to_back(input int count);
        logic [63:0] lo;
        logic [63:0] hi;
        drain_results();
        idle_on = 1'b0;
        for (int i = 0; i < count; i++)
        begin
            pick_range(lo, hi);
            if ($urandom_range(0, 9) == 0)
                send_seed(rand64());
            else
                send_draw(lo, hi);
        end
        idle_on = 1'b1;
    endtask

    // Mostly draws with random ranges, some reseeds and a full drain now and then.
    task automatic test_random_items(input int count);
        logic [63:0] lo;
        logic [63:0] hi;
        for (int i = 0; i < count; i++)
        begin
            if (i % 200 == 199)
                drain_results();
            pick_range(lo, hi);
            case ($urandom_range(0, 19))
                0, 1: send_seed(rand64());
                2: send_seed(($urandom_range(0, 7) == 0) ? 64'd0 : rand64() >> 40);
                default: send_draw(lo, hi);
            endcase
        end
    endtask

    // Result side: pop runs and stalls of random length.
    initial
    begin : drive_pop
        int gap;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            gap = pick_gap();
            if (gap > 0)
            begin
                pop <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            pop <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    end

    // Compares each popped draw with the oldest expectation.
    always @(posedge clk)
    begin : check_draws
        logic [63:0] want;
        if (rst_n && pop && !empty)
        begin
            if (expected_draws.size() == 0)
            begin
                report_error("drawn_value with no pending draw", 64'd0, drawn_value);
            end
            else
            begin
                want = expected_draws.pop_front();
                if (drawn_value !== want)
                    report_error("drawn_value", want, drawn_value);
            end
        end
    end

    // Test sequence.
    initial
    begin
        shadow_state = STATE_RESET;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_draws();
        test_empty_ranges();
        test_zero_seed();
        test_extreme_ranges();
        test_back_to_back(100);
        test_random_items(700);

        // Let the last draws drain, then watch for stray results.
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (expected_draws.size() != 0)
            report_error("draws never returned, count", 64'(expected_draws.size()), 64'd0);

        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
